/* rtl/core/cbwwf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CIGAR base weight window finder package
// Shared widths, codes, state encodings and controller/datapath structs.
// ----------------------------------------------------------------------------
package cbwwf_pkg;

	localparam int LIM_W      = 17;
	localparam int LEN_W      = 13;
	localparam int SIM_W      = 17;
	localparam int QLEN_W     = 16;
	localparam int CNT_W      = 16;
	localparam int START_W    = 12;
	localparam int WIN_SUM_W  = 28;
	localparam int PROD_W     = 33;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	typedef logic [1:0]           cigar_op_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cigar_op_t OP_M = 2'd0;
	localparam cigar_op_t OP_X = 2'd1;
	localparam cigar_op_t OP_D = 2'd3;

	localparam logic REQ_FIND     = 1'b1;
	localparam logic KIND_VERDICT = 1'b0;
	localparam logic KIND_WINDOW  = 1'b1;

	localparam cfg_idx_t CFG_WINDOW_LEN    = 2'd0;
	localparam cfg_idx_t CFG_SEQ_LEN       = 2'd1;
	localparam cfg_idx_t CFG_MIN_SIMILARITY = 2'd2;

	localparam logic [LEN_W-1:0]     WIN_LEN_RST = 13'd1;
	localparam logic [LEN_W-1:0]     SEQ_LEN_RST = 13'd4096;
	localparam logic [CNT_W-1:0]     CNT_MAX     = 16'hFFFF;
	localparam logic [WIN_SUM_W-1:0] SUM_MAX     = 28'hFFF_FFFF;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_MUL,
		ST_CMP,
		ST_COMMIT,
		ST_CDRN,
		ST_PUT_V,
		ST_SCAN,
		ST_SDR1,
		ST_SDR2,
		ST_PUT_W,
		ST_WIPE
	} state_t;

	typedef enum logic [1:0] {
		SW_INIT,
		SW_COMMIT,
		SW_SCAN,
		SW_WIPE
	} sweep_t;

	typedef struct packed {
		logic   valid;
		logic   find;
		logic   last;
	} req_info_t;

	typedef struct packed {
		logic   sweep_en;
		sweep_t sweep_kind;
		logic   op_take;
		logic   scan_init;
		logic   load_verdict;
		logic   load_window;
	} ctrl_cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic sweep_empty;
		logic out_free;
	} dp_status_t;

endpackage

/* rtl/core/cbwwf_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CIGAR base weight window finder configuration channel
// Register write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface cbwwf_cfg_if import cbwwf_pkg::*; ();
	logic                  valid;
	logic                  ready;
	cfg_idx_t              idx;
	logic [CFG_DATA_W-1:0] wdata;

	modport source (output valid, idx, wdata, input ready);
	modport sink (input valid, idx, wdata, output ready);
endinterface

/* rtl/core/cbwwf_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CIGAR base weight window finder request channel
// Carries one CIGAR operation or one find request per item.
// ----------------------------------------------------------------------------
interface cbwwf_req_if import cbwwf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              req_type;
	cigar_op_t         cigar_op;
	logic              last_op;
	logic [QLEN_W-1:0] query_len;

	modport source (output valid, req_type, cigar_op, last_op, query_len, input ready);
	modport sink (input valid, req_type, cigar_op, last_op, query_len, output ready);
endinterface

/* rtl/core/cbwwf_res_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CIGAR base weight window finder result channel
// Carries an alignment verdict or a window answer per item.
// ----------------------------------------------------------------------------
interface cbwwf_res_if import cbwwf_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 result_kind;
	logic                 accepted;
	logic [CNT_W-1:0]     match_count;
	logic                 found;
	logic [START_W-1:0]   window_start;
	logic [WIN_SUM_W-1:0] window_weight;

	modport source (output valid, result_kind, accepted, match_count, found,
		window_start, window_weight, input ready);
	modport sink (input valid, result_kind, accepted, match_count, found,
		window_start, window_weight, output ready);
endinterface

/* rtl/core/cigar_base_weight_window_finder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CIGAR base weight window finder
// Accumulates per-position base weights from passing alignments and reports
// the heaviest sliding window on request.
// ----------------------------------------------------------------------------
// Channel  Direction  Item
// cfg      in         register index and write data
// req      in         one CIGAR operation or one find request
// res      out        alignment verdict or window answer
//
// An operation that does not end an alignment leaves the controller idle and
// ready for the next request. A final operation is followed by the threshold
// test, a commit sweep over the mark and weight stores up to the final
// position index clamped to MAX_SEQ, and the verdict. A find runs the window
// scan over seq_len clamped to MAX_SEQ, then the store wipe.
// After reset the stores are cleared before req is ready.
// A stalled result holds in the output register; operations are still taken.
// ----------------------------------------------------------------------------
module cigar_base_weight_window_finder import cbwwf_pkg::*; #(
	parameter int MAX_SEQ     = 4096,
	parameter int WEIGHT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	cbwwf_cfg_if.sink   cfg,
	cbwwf_req_if.sink   req,
	cbwwf_res_if.source res
);

	req_info_t  req_info;
	logic       req_ready;
	ctrl_cmd_t  cmd;
	dp_status_t status;

	assign req_info.valid = req.valid;
	assign req_info.find  = (req.req_type == REQ_FIND);
	assign req_info.last  = req.last_op;
	assign req.ready      = req_ready;

	cbwwf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_info  (req_info),
		.req_ready (req_ready),
		.status    (status),
		.cmd       (cmd)
	);

	cbwwf_dp #(
		.MAX_SEQ     (MAX_SEQ),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cigar_op  (req.cigar_op),
		.last_op   (req.last_op),
		.query_len (req.query_len),
		.res       (res),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

/* rtl/core/cbwwf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CIGAR base weight window finder controller
// Sequences operation intake, commit sweeps, window scans and store clears.
// ----------------------------------------------------------------------------
module cbwwf_ctrl import cbwwf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  req_info_t  req_info,
	output logic       req_ready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;
	logic   sweep_end;

	assign sweep_end = status.sweep_last || status.sweep_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLR: begin
				if (sweep_end) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_info.valid) begin
					if (req_info.find) state_d = ST_SCAN;
					else if (req_info.last) state_d = ST_MUL;
				end
			end
			ST_MUL:    state_d = ST_CMP;
			ST_CMP:    state_d = ST_COMMIT;
			ST_COMMIT: begin
				if (sweep_end) state_d = ST_CDRN;
			end
			ST_CDRN:   state_d = ST_PUT_V;
			ST_PUT_V: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (sweep_end) state_d = ST_SDR1;
			end
			ST_SDR1:   state_d = ST_SDR2;
			ST_SDR2:   state_d = ST_PUT_W;
			ST_PUT_W: begin
				if (status.out_free) state_d = ST_WIPE;
			end
			ST_WIPE: begin
				if (sweep_end) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready        = 1'b0;
		cmd.sweep_en     = 1'b0;
		cmd.sweep_kind   = SW_INIT;
		cmd.op_take      = 1'b0;
		cmd.scan_init    = 1'b0;
		cmd.load_verdict = 1'b0;
		cmd.load_window  = 1'b0;
		case (state_q)
			ST_CLR: begin
				cmd.sweep_en   = 1'b1;
				cmd.sweep_kind = SW_INIT;
			end
			ST_IDLE: begin
				req_ready     = 1'b1;
				cmd.op_take   = req_info.valid && !req_info.find;
				cmd.scan_init = req_info.valid && req_info.find;
			end
			ST_COMMIT: begin
				cmd.sweep_en   = 1'b1;
				cmd.sweep_kind = SW_COMMIT;
			end
			ST_PUT_V: begin
				cmd.load_verdict = status.out_free;
			end
			ST_SCAN: begin
				cmd.sweep_en   = 1'b1;
				cmd.sweep_kind = SW_SCAN;
			end
			ST_PUT_W: begin
				cmd.load_window = status.out_free;
			end
			ST_WIPE: begin
				cmd.sweep_en   = 1'b1;
				cmd.sweep_kind = SW_WIPE;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

endmodule

/* rtl/core/cbwwf_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CIGAR base weight window finder datapath
// Configuration registers, alignment counters, mark and weight stores,
// threshold test, sliding window scan and the result register.
// ----------------------------------------------------------------------------
module cbwwf_dp import cbwwf_pkg::*; #(
	parameter int MAX_SEQ     = 4096,
	parameter int WEIGHT_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	cbwwf_cfg_if.sink         cfg,
	input  cigar_op_t         cigar_op,
	input  logic              last_op,
	input  logic [QLEN_W-1:0] query_len,
	cbwwf_res_if.source       res,
	input  ctrl_cmd_t         cmd,
	output dp_status_t        status
);

	localparam int AW     = (MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1;
	localparam int CW     = $clog2(MAX_SEQ + 1);
	localparam int SUM_A  = AW + WEIGHT_BITS + 1;
	localparam int SUM_W  = (SUM_A > WIN_SUM_W + 1) ? SUM_A : WIN_SUM_W + 1;
	localparam logic [LIM_W-1:0]       MAX_LIM = LIM_W'(MAX_SEQ);
	localparam logic [WEIGHT_BITS-1:0] W_MAX   = '1;

	logic [LEN_W-1:0]  win_len_q;
	logic [LEN_W-1:0]  seq_len_q;
	logic [SIM_W-1:0]  min_sim_q;

	logic [CNT_W-1:0]  pidx_q;
	logic [CNT_W-1:0]  mc_q;
	logic [QLEN_W-1:0] qlen_q;
	logic [PROD_W-1:0] prod_q;
	logic              pass_q;

	logic [CW-1:0]     cnt_q;
	logic [LIM_W-1:0]  cnt_ext;
	logic [LIM_W-1:0]  k_ext;
	logic [LIM_W-1:0]  used_lim;
	logic [LIM_W-1:0]  commit_lim;
	logic [LIM_W-1:0]  sweep_lim;
	logic [LIM_W-1:0]  tail_diff;
	logic [LIM_W-1:0]  start_full;
	logic [AW-1:0]     addr;
	logic              issue;
	logic              wipe_issue;

	logic              op_mx;
	logic              mark_we;
	logic [AW-1:0]     mark_wa;
	logic              mark_wd;
	logic              marks_mem [MAX_SEQ];
	logic              mark_rd_q;

	logic [WEIGHT_BITS-1:0] w_mem [MAX_SEQ];
	logic [WEIGHT_BITS-1:0] w_rd_a_q;
	logic [WEIGHT_BITS-1:0] w_rd_b_q;
	logic                   w_we;
	logic [AW-1:0]          w_wa;
	logic [WEIGHT_BITS-1:0] w_wd;
	logic [WEIGHT_BITS-1:0] w_new;

	logic               cv_s1;
	logic [AW-1:0]      caddr_s1;
	logic               sv_s1;
	logic               ge_s1;
	logic [START_W-1:0] start_s1;
	logic               sv_s2;
	logic               ge_s2;
	logic [START_W-1:0] start_s2;
	logic [SUM_W-1:0]   acc_q;
	logic [SUM_W-1:0]   best_q;
	logic [START_W-1:0] best_i_q;

	logic                 res_valid_q;
	logic                 kind_q;
	logic                 accepted_q;
	logic [CNT_W-1:0]     match_count_q;
	logic                 found_q;
	logic [START_W-1:0]   start_q;
	logic [WIN_SUM_W-1:0] weight_q;

	// Configuration registers; the port never stalls.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q <= WIN_LEN_RST;
			seq_len_q <= SEQ_LEN_RST;
			min_sim_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.idx)
				CFG_WINDOW_LEN:     win_len_q <= cfg.wdata[LEN_W-1:0];
				CFG_SEQ_LEN:        seq_len_q <= cfg.wdata[LEN_W-1:0];
				CFG_MIN_SIMILARITY: min_sim_q <= cfg.wdata[SIM_W-1:0];
				default:            win_len_q <= win_len_q;
			endcase
		end
	end

	// Sweep counter shared by reset clear, commit, scan and wipe.
	assign cnt_ext    = LIM_W'(cnt_q);
	assign k_ext      = LIM_W'(win_len_q);
	assign used_lim   = (LIM_W'(seq_len_q) < MAX_LIM) ? LIM_W'(seq_len_q) : MAX_LIM;
	assign commit_lim = (LIM_W'(pidx_q) < MAX_LIM) ? LIM_W'(pidx_q) : MAX_LIM;

	always_comb begin
		case (cmd.sweep_kind)
			SW_COMMIT: sweep_lim = commit_lim;
			SW_SCAN:   sweep_lim = used_lim;
			default:   sweep_lim = MAX_LIM;
		endcase
	end

	assign status.sweep_empty = (sweep_lim == '0);
	assign status.sweep_last  = (cnt_ext + LIM_W'(1)) >= sweep_lim;
	assign issue      = cmd.sweep_en && !status.sweep_empty;
	assign wipe_issue = issue && (cmd.sweep_kind == SW_INIT || cmd.sweep_kind == SW_WIPE);
	assign addr       = cnt_q[AW-1:0];
	assign tail_diff  = cnt_ext - k_ext;
	assign start_full = tail_diff + LIM_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.sweep_en) begin
			cnt_q <= cnt_q + CW'(1);
		end else begin
			cnt_q <= '0;
		end
	end

	// Alignment counters.
	assign op_mx = (cigar_op == OP_M) || (cigar_op == OP_X);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pidx_q <= '0;
			mc_q   <= '0;
		end else if (cmd.load_verdict) begin
			pidx_q <= '0;
			mc_q   <= '0;
		end else if (cmd.op_take) begin
			if (cigar_op != OP_D && pidx_q != CNT_MAX) pidx_q <= pidx_q + CNT_W'(1);
			if (cigar_op == OP_M && mc_q != CNT_MAX) mc_q <= mc_q + CNT_W'(1);
		end
	end

	// Threshold test: match_count * 2^16 against min_similarity * query_len.
	always_ff @(posedge clk) begin
		if (cmd.op_take && last_op) qlen_q <= query_len;
		prod_q <= PROD_W'(min_sim_q) * PROD_W'(qlen_q);
		pass_q <= {1'b0, mc_q, 16'h0000} >= prod_q;
	end

	// Mark store.
	always_comb begin
		mark_we = 1'b0;
		mark_wa = addr;
		mark_wd = 1'b0;
		if (issue && (cmd.sweep_kind == SW_INIT || cmd.sweep_kind == SW_COMMIT)) begin
			mark_we = 1'b1;
		end else if (cmd.op_take && op_mx && (LIM_W'(pidx_q) < used_lim)) begin
			mark_we = 1'b1;
			mark_wa = pidx_q[AW-1:0];
			mark_wd = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mark_we) marks_mem[mark_wa] <= mark_wd;
		mark_rd_q <= marks_mem[addr];
	end

	// Weight store.
	assign w_new = (mark_rd_q && pass_q && w_rd_a_q != W_MAX) ?
		w_rd_a_q + WEIGHT_BITS'(1) : w_rd_a_q;

	always_comb begin
		w_we = 1'b0;
		w_wa = addr;
		w_wd = '0;
		if (wipe_issue) begin
			w_we = 1'b1;
		end else if (cv_s1) begin
			w_we = 1'b1;
			w_wa = caddr_s1;
			w_wd = w_new;
		end
	end

	always_ff @(posedge clk) begin
		if (w_we) w_mem[w_wa] <= w_wd;
		w_rd_a_q <= w_mem[addr];
		w_rd_b_q <= w_mem[tail_diff[AW-1:0]];
	end

	// Commit and scan pipelines.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_s1 <= 1'b0;
			sv_s1 <= 1'b0;
			sv_s2 <= 1'b0;
		end else begin
			cv_s1 <= issue && (cmd.sweep_kind == SW_COMMIT);
			sv_s1 <= issue && (cmd.sweep_kind == SW_SCAN);
			sv_s2 <= sv_s1;
		end
	end

	always_ff @(posedge clk) begin
		caddr_s1 <= addr;
		ge_s1    <= cnt_ext >= k_ext;
		start_s1 <= start_full[START_W-1:0];
		ge_s2    <= ge_s1;
		start_s2 <= start_s1;
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			acc_q <= '0;
		end else if (sv_s1) begin
			acc_q <= acc_q + SUM_W'(w_rd_a_q) - (ge_s1 ? SUM_W'(w_rd_b_q) : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			best_q   <= '0;
			best_i_q <= '0;
		end else if (sv_s2) begin
			if (!ge_s2) begin
				best_q <= acc_q;
			end else if (acc_q > best_q) begin
				best_q   <= acc_q;
				best_i_q <= start_s2;
			end
		end
	end

	// Result register.
	assign status.out_free = !res_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load_verdict || cmd.load_window) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_verdict) begin
			kind_q        <= KIND_VERDICT;
			accepted_q    <= pass_q;
			match_count_q <= mc_q;
			found_q       <= 1'b0;
			start_q       <= '0;
			weight_q      <= '0;
		end else if (cmd.load_window) begin
			kind_q        <= KIND_WINDOW;
			accepted_q    <= 1'b0;
			match_count_q <= '0;
			found_q       <= best_q >= SUM_W'(win_len_q);
			start_q       <= best_i_q;
			weight_q      <= (best_q > SUM_W'(SUM_MAX)) ? SUM_MAX : best_q[WIN_SUM_W-1:0];
		end
	end

	assign res.valid         = res_valid_q;
	assign res.result_kind   = kind_q;
	assign res.accepted      = accepted_q;
	assign res.match_count   = match_count_q;
	assign res.found         = found_q;
	assign res.window_start  = start_q;
	assign res.window_weight = weight_q;

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CIGAR base weight window finder testbench
// Feeds CIGAR operations and find requests through the request channel, with
// random gaps on both channels and long receiver hold-offs. A scoring model
// in the bench predicts every verdict and window answer, and the monitor
// checks each result item against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import cbwwf_pkg::*;

	localparam int          MAX_SEQ      = 4096;
	localparam int          WEIGHT_BITS  = 16;
	localparam int unsigned WEIGHT_MAX   = (1 << WEIGHT_BITS) - 1;
	localparam int unsigned CLK_PERIOD   = 10;
	localparam int unsigned QUIET        = MAX_SEQ + 128;
	localparam int unsigned HOLD_CYCLES  = 600;
	localparam int unsigned LIMIT        = 6000000;
	localparam cigar_op_t   OP_I         = 2'd2;
	localparam logic        REQ_OP       = 1'b0;

	typedef struct packed {
		logic              req_type;
		cigar_op_t         cigar_op;
		logic              last_op;
		logic [QLEN_W-1:0] query_len;
	} cigar_req_t;

	typedef struct packed {
		logic                 result_kind;
		logic                 accepted;
		logic [CNT_W-1:0]     match_count;
		logic                 found;
		logic [START_W-1:0]   window_start;
		logic [WIN_SUM_W-1:0] window_weight;
	} finder_res_t;

	logic clk = 1'b0;
	logic arst_n;

	cbwwf_cfg_if cfg_ch ();
	cbwwf_req_if req_ch ();
	cbwwf_res_if res_ch ();

	cigar_base_weight_window_finder #(
		.MAX_SEQ    (MAX_SEQ),
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_ch),
		.req   (req_ch),
		.res   (res_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	cigar_req_t  pending_reqs[$];
	finder_res_t expected_res[$];

	int unsigned win_len_m = 32'(WIN_LEN_RST);
	int unsigned seq_len_m = 32'(SEQ_LEN_RST);
	int unsigned min_sim_m = 0;
	int unsigned weight_m[MAX_SEQ];
	bit          mark_m[MAX_SEQ];
	int unsigned marked_pos[$];
	int unsigned pos_m     = 0;
	int unsigned matches_m = 0;

	int unsigned bad_count   = 0;
	int unsigned cycle_count = 0;
	int unsigned queued      = 0;
	int unsigned send_gap    = 0;
	int unsigned stall_left  = 0;
	int unsigned hold_left   = 0;
	int unsigned hold_asked  = 0;
	int unsigned hold_given  = 0;
	bit          src_idle    = 1'b1;
	bit          snk_idle    = 1'b1;
	logic        req_taken   = 1'b0;
	cigar_req_t  next_req;
	finder_res_t want, got;

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic void score_request(cigar_req_t r);
		int unsigned used, head, best_i, i, p;
		longint unsigned acc, best;
		bit pass;
		finder_res_t res_e;
		res_e = '0;
		used = (seq_len_m < MAX_SEQ) ? seq_len_m : MAX_SEQ;
		if (r.req_type == REQ_FIND) begin
			head = (win_len_m < used) ? win_len_m : used;
			acc = 0;
			best_i = 0;
			for (i = 0; i < head; i++)
				acc += weight_m[i];
			best = acc;
			for (i = win_len_m; i < used; i++) begin
				acc = acc - weight_m[i - win_len_m] + weight_m[i];
				if (acc > best) begin
					best = acc;
					best_i = i - win_len_m + 1;
				end
			end
			res_e.result_kind = KIND_WINDOW;
			res_e.found = (best >= win_len_m);
			res_e.window_start = best_i[START_W-1:0];
			res_e.window_weight = (best > SUM_MAX) ? SUM_MAX : best[WIN_SUM_W-1:0];
			for (i = 0; i < MAX_SEQ; i++)
				weight_m[i] = 0;
			expected_res.push_back(res_e);
		end else begin
			if (r.cigar_op == OP_M || r.cigar_op == OP_X) begin
				if (pos_m < used && !mark_m[pos_m]) begin
					mark_m[pos_m] = 1'b1;
					marked_pos.push_back(pos_m);
				end
				if (r.cigar_op == OP_M && matches_m < CNT_MAX)
					matches_m++;
			end
			if (r.cigar_op != OP_D && pos_m < CNT_MAX)
				pos_m++;
			if (r.last_op) begin
				pass = (64'(matches_m) << 16) >= 64'(min_sim_m) * 64'(r.query_len);
				for (i = 0; i < marked_pos.size(); i++) begin
					p = marked_pos[i];
					if (pass && weight_m[p] < WEIGHT_MAX)
						weight_m[p]++;
					mark_m[p] = 1'b0;
				end
				marked_pos.delete();
				res_e.result_kind = KIND_VERDICT;
				res_e.accepted = pass;
				res_e.match_count = matches_m[CNT_W-1:0];
				pos_m = 0;
				matches_m = 0;
				expected_res.push_back(res_e);
			end
		end
	endfunction

	task automatic push_op(cigar_op_t op, logic last, logic [QLEN_W-1:0] q);
		cigar_req_t r;
		r.req_type = REQ_OP;
		r.cigar_op = op;
		r.last_op = last;
		r.query_len = q;
		pending_reqs.push_back(r);
		queued++;
	endtask

	task automatic push_find();
		cigar_req_t r;
		r.req_type = REQ_FIND;
		r.cigar_op = cigar_op_t'($urandom_range(0, 3));
		r.last_op = 1'($urandom_range(0, 1));
		r.query_len = QLEN_W'($urandom);
		pending_reqs.push_back(r);
		queued++;
	endtask

	task automatic add_alignment();
		int unsigned len, m, i, r;
		cigar_op_t op;
		logic [QLEN_W-1:0] q;
		r = $urandom_range(0, 99);
		len = (r < 85) ? $urandom_range(1, 16) :
			(r < 97) ? $urandom_range(17, 80) : $urandom_range(200, 600);
		m = 0;
		for (i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			op = (r < 50) ? OP_M : (r < 70) ? OP_X : (r < 85) ? OP_I : OP_D;
			if (op == OP_M)
				m++;
			if (i + 1 < len) begin
				push_op(op, 1'b0, QLEN_W'($urandom));
				if ($urandom_range(0, 199) == 0)
					push_find();
			end else begin
				case ($urandom_range(0, 19))
					0: q = '0;
					1: q = '1;
					2, 3: q = QLEN_W'($urandom);
					default: q = QLEN_W'($urandom_range(m / 2, m + m / 2 + 1));
				endcase
				push_op(op, 1'b1, q);
			end
		end
	endtask

	task automatic cfg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.idx <= idx;
		cfg_ch.wdata <= data;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		case (idx)
			CFG_WINDOW_LEN:     win_len_m = 32'(data[LEN_W-1:0]);
			CFG_SEQ_LEN:        seq_len_m = 32'(data[LEN_W-1:0]);
			CFG_MIN_SIMILARITY: min_sim_m = 32'(data[SIM_W-1:0]);
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic random_config();
		logic [LEN_W-1:0] w, s;
		logic [SIM_W-1:0] t;
		case ($urandom_range(0, 6))
			0: w = '0;
			1: w = LEN_W'(1);
			2: w = LEN_W'($urandom_range(2, 8));
			3: w = LEN_W'($urandom_range(1, 64));
			4: w = LEN_W'($urandom_range(1, 4096));
			5: w = LEN_W'(4096);
			default: w = LEN_W'(8191);
		endcase
		case ($urandom_range(0, 6))
			0: s = LEN_W'(1);
			1: s = LEN_W'($urandom_range(2, 32));
			2: s = LEN_W'($urandom_range(33, 600));
			3: s = LEN_W'($urandom_range(1, 4096));
			4: s = LEN_W'(4096);
			5: s = LEN_W'(8191);
			default: s = LEN_W'($urandom_range(4097, 8191));
		endcase
		case ($urandom_range(0, 4))
			0: t = '0;
			1: t = SIM_W'(65536);
			2: t = 17'h1FFFF;
			3: t = SIM_W'($urandom_range(0, 65536));
			default: t = SIM_W'($urandom_range(32768, 65536));
		endcase
		cfg_write(CFG_WINDOW_LEN, {4'($urandom), w});
		cfg_write(CFG_SEQ_LEN, {4'($urandom), s});
		cfg_write(CFG_MIN_SIMILARITY, t);
	endtask

	task automatic settle();
		while (pending_reqs.size() != 0 || req_ch.valid || expected_res.size() != 0)
			@(posedge clk);
		repeat (QUIET) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_ch.valid || req_taken) begin
				if (send_gap > 0) begin
					send_gap--;
					req_ch.valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					next_req = pending_reqs.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.req_type <= next_req.req_type;
					req_ch.cigar_op <= next_req.cigar_op;
					req_ch.last_op <= next_req.last_op;
					req_ch.query_len <= next_req.query_len;
					send_gap = src_idle ? idle_len() : 0;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else if (snk_idle && $urandom_range(0, 99) < 25) begin
				stall_left = idle_len();
				res_ch.ready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (hold_left > 0)
			hold_left <= hold_left - 1;
		else if (hold_asked != hold_given) begin
			hold_left <= HOLD_CYCLES;
			hold_given <= hold_given + 1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		req_taken <= req_ch.valid && req_ch.ready;
		if (res_ch.valid && res_ch.ready) begin
			got = {res_ch.result_kind, res_ch.accepted, res_ch.match_count, res_ch.found,
				res_ch.window_start, res_ch.window_weight};
			if (expected_res.size() == 0) begin
				bad_count++;
				if (bad_count <= 10)
					$display("unexpected result item: kind %0d at %0t", got.result_kind, $realtime);
			end else begin
				want = expected_res.pop_front();
				if (got !== want) begin
					bad_count++;
					if (bad_count <= 10)
						$display({"result mismatch at %0t: kind %0d/%0d accepted %0d/%0d ",
							"matches %0d/%0d found %0d/%0d start %0d/%0d weight %0d/%0d ",
							"(expected/actual)"}, $realtime,
							want.result_kind, got.result_kind, want.accepted, got.accepted,
							want.match_count, got.match_count, want.found, got.found,
							want.window_start, got.window_start,
							want.window_weight, got.window_weight);
				end
			end
		end
		if (req_ch.valid && req_ch.ready)
			score_request({req_ch.req_type, req_ch.cigar_op, req_ch.last_op, req_ch.query_len});
	end

	initial begin
		wait (cycle_count == LIMIT);
		$display("cigar_base_weight_window_finder regression: fail");
		$finish;
	end

	initial begin
		int unsigned i, ph;
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.idx = CFG_WINDOW_LEN;
		cfg_ch.wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_OP;
		req_ch.cigar_op = OP_M;
		req_ch.last_op = 1'b0;
		req_ch.query_len = '0;
		res_ch.ready = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Settings after reset: empty store, every operation, a find in the
		// middle of an alignment and an alignment made of a single deletion.
		push_find();
		push_op(OP_M, 1'b0, 16'h0000);
		push_op(OP_X, 1'b0, 16'hFFFF);
		push_op(OP_I, 1'b0, 16'h5A5A);
		push_op(OP_D, 1'b0, 16'hA5A5);
		push_op(OP_M, 1'b1, 16'hFFFF);
		push_op(OP_X, 1'b0, 16'h0001);
		push_op(OP_M, 1'b0, 16'h0001);
		push_op(OP_M, 1'b1, 16'h0001);
		push_op(OP_D, 1'b1, 16'h0000);
		push_op(OP_M, 1'b0, 16'h0003);
		push_find();
		push_op(OP_I, 1'b1, 16'h0002);
		push_find();
		settle();

		// Threshold above one, a window longer than the sequence and
		// positions beyond the sequence end.
		cfg_write(CFG_MIN_SIMILARITY, 17'h1FFFF);
		cfg_write(CFG_WINDOW_LEN, 17'h1FFFF);
		cfg_write(CFG_SEQ_LEN, 17'd3);
		push_op(OP_M, 1'b1, 16'h0000);
		push_op(OP_M, 1'b0, 16'h0000);
		push_op(OP_M, 1'b1, 16'h0001);
		push_op(OP_M, 1'b0, 16'h0000);
		push_op(OP_X, 1'b1, 16'hFFFF);
		for (i = 0; i < 4; i++)
			push_op(OP_M, 1'b0, 16'h0000);
		push_op(OP_X, 1'b1, 16'h0000);
		push_find();
		settle();

		// Exact threshold of one, zero window length and an empty sequence.
		cfg_write(CFG_MIN_SIMILARITY, 17'd65536);
		cfg_write(CFG_WINDOW_LEN, 17'd0);
		cfg_write(CFG_SEQ_LEN, 17'd0);
		push_op(OP_M, 1'b0, 16'h0000);
		push_op(OP_M, 1'b0, 16'h0000);
		push_op(OP_X, 1'b1, 16'h0002);
		push_op(OP_M, 1'b0, 16'h0000);
		push_op(OP_X, 1'b1, 16'h0002);
		push_find();
		settle();

		// One long alignment sent back to back, with the oversized seq_len
		// clamped.
		src_idle = 1'b0;
		snk_idle = 1'b0;
		cfg_write(CFG_WINDOW_LEN, 17'd4096);
		cfg_write(CFG_SEQ_LEN, 17'd8191);
		push_op(OP_I, 1'b0, 16'h0000);
		push_op(OP_D, 1'b0, 16'h0000);
		push_op(OP_X, 1'b0, 16'h0000);
		for (i = 0; i < 160; i++)
			push_op(OP_M, 1'b0, QLEN_W'($urandom));
		push_op(OP_M, 1'b1, 16'hFFFF);
		push_find();
		settle();

		// Many passing alignments piling weight onto the same positions.
		cfg_write(CFG_WINDOW_LEN, 17'd2);
		cfg_write(CFG_SEQ_LEN, 17'd4);
		cfg_write(CFG_MIN_SIMILARITY, 17'd0);
		for (i = 0; i < 64; i++)
			push_op(OP_M, 1'b1, QLEN_W'($urandom));
		for (i = 0; i < 3; i++) begin
			push_op(OP_I, 1'b0, QLEN_W'($urandom));
			push_op(OP_M, 1'b1, QLEN_W'($urandom));
		end
		push_op(OP_X, 1'b1, 16'h0001);
		push_find();
		settle();

		for (ph = 0; ph < 6; ph++) begin
			random_config();
			src_idle = (ph != 3);
			snk_idle = (ph != 3);
			if (ph == 1) begin
				@(negedge clk);
				hold_asked++;
			end
			queued = 0;
			while (queued < 250) begin
				if ($urandom_range(0, 99) < 5)
					push_find();
				else
					add_alignment();
			end
			push_find();
			settle();
		end

		bad_count += expected_res.size();
		if (bad_count == 0)
			$display("cigar_base_weight_window_finder regression: pass");
		else
			$display("cigar_base_weight_window_finder regression: fail");
		$finish;
	end

endmodule
